// File: rtl/pil_pkg.sv
// Shared types and constants for the positional insert and erase list.
package pil_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W = 4;
	localparam int CNT_W = 5;
	localparam int DATA_W = 32;

	localparam logic [2:0] ACT_PUSH = 3'd0;
	localparam logic [2:0] ACT_POP = 3'd1;
	localparam logic [2:0] ACT_INSERT = 3'd2;
	localparam logic [2:0] ACT_ERASE = 3'd3;
	localparam logic [2:0] ACT_READ = 3'd4;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_FROM_BELOW,
		CELL_FROM_ABOVE
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
	} cell_ctrl_t;

endpackage

// File: rtl/pil_cell.sv
// One storage cell of the list, able to load, hold, or take a neighbor's word.
module pil_cell import pil_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cell_ctrl_t        ctrl,
	input  logic [DATA_W-1:0] load_data,
	input  logic [DATA_W-1:0] below_data,
	input  logic [DATA_W-1:0] above_data,
	output logic [DATA_W-1:0] data
);

	logic [DATA_W-1:0] data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q <= '0;
		end else begin
			case (ctrl.op)
				CELL_LOAD:       data_q <= load_data;
				CELL_FROM_BELOW: data_q <= below_data;
				CELL_FROM_ABOVE: data_q <= above_data;
				default:         data_q <= data_q;
			endcase
		end
	end

	assign data = data_q;

endmodule

// File: rtl/positional_insert_erase_list_core.sv
// Top level: a row of word cells with per-cell shift control and a registered result.
// Latency: the result of an item is registered and appears in the cycle after it is accepted, strobed by done.
// Throughput: one item per cycle; every cell shifts in parallel, so busy stays low.
// Reset: arst_n clears all cells to zero, the fill count to zero and the result strobe.
// The receiver cannot stall; each result is valid for exactly one cycle.
module positional_insert_erase_list_core import pil_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [2:0]               action,
	input  logic [IDX_W-1:0]         position,
	input  logic signed [DATA_W-1:0] value,
	output logic                     done,
	output logic                     ok,
	output logic signed [DATA_W-1:0] read_value,
	output logic [CNT_W-1:0]         count
);

	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	logic [DATA_W-1:0] cell_data [CAPACITY];
	cell_ctrl_t        cell_ctrl [CAPACITY];
	logic [CNT_W-1:0]  fill_q;
	logic [CNT_W-1:0]  pos_ext;
	logic [CNT_W-1:0]  fill_d;
	logic              accept;
	logic              ok_d;
	logic [DATA_W-1:0] rd_d;
	logic              done_q;
	logic              ok_q;
	logic [DATA_W-1:0] rd_q;

	assign busy = 1'b0;
	assign accept = start && !busy;
	assign pos_ext = {1'b0, position};

	always_comb begin
		ok_d = 1'b0;
		rd_d = '0;
		fill_d = fill_q;
		unique case (action)
			ACT_PUSH: begin
				ok_d = fill_q < CAP_CNT;
				if (ok_d) fill_d = fill_q + 1'b1;
			end
			ACT_POP: begin
				ok_d = fill_q != '0;
				if (ok_d) fill_d = fill_q - 1'b1;
			end
			ACT_INSERT: begin
				ok_d = (fill_q < CAP_CNT) && (pos_ext <= fill_q);
				if (ok_d) fill_d = fill_q + 1'b1;
			end
			ACT_ERASE: begin
				ok_d = pos_ext < fill_q;
				if (ok_d) fill_d = fill_q - 1'b1;
			end
			ACT_READ: begin
				ok_d = pos_ext < CAP_CNT;
				if (ok_d) rd_d = cell_data[position];
			end
			default: begin
				ok_d = 1'b0;
			end
		endcase
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
		logic [DATA_W-1:0] below_w;
		logic [DATA_W-1:0] above_w;

		if (i == 0) begin : g_first
			assign below_w = '0;
		end else begin : g_below
			assign below_w = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign above_w = '0;
		end else begin : g_above
			assign above_w = cell_data[i+1];
		end

		always_comb begin
			cell_ctrl[i].op = CELL_HOLD;
			if (accept && ok_d) begin
				case (action)
					ACT_PUSH: begin
						if (IDX == fill_q) cell_ctrl[i].op = CELL_LOAD;
					end
					ACT_INSERT: begin
						if (IDX == pos_ext) cell_ctrl[i].op = CELL_LOAD;
						else if (IDX > pos_ext) cell_ctrl[i].op = CELL_FROM_BELOW;
					end
					ACT_ERASE: begin
						if (IDX >= pos_ext && (IDX + 1'b1) < fill_q)
							cell_ctrl[i].op = CELL_FROM_ABOVE;
					end
					default: begin
						cell_ctrl[i].op = CELL_HOLD;
					end
				endcase
			end
		end

		pil_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (cell_ctrl[i]),
			.load_data  (value),
			.below_data (below_w),
			.above_data (above_w),
			.data       (cell_data[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			done_q <= 1'b0;
			ok_q <= 1'b0;
			rd_q <= '0;
		end else begin
			done_q <= accept;
			if (accept) begin
				fill_q <= fill_d;
				ok_q <= ok_d;
				rd_q <= rd_d;
			end
		end
	end

	assign done = done_q;
	assign ok = ok_q;
	assign read_value = rd_q;
	assign count = fill_q;

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("result strobe missing after an accepted item");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CAP_CNT)
		else $error("fill count exceeds capacity");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && action == ACT_PUSH && fill_q < CAP_CNT) |=> fill_q == $past(fill_q) + 1'b1)
		else $error("successful push did not grow the list");

	a_reject_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !ok_d) |=> (fill_q == $past(fill_q)) && !ok)
		else $error("rejected item changed the fill count");

	a_read_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && read_value != '0) |-> ok)
		else $error("nonzero read word on a rejected item");

endmodule
